/* src/trilinear_volume_colour_modulate_macros.svh */
// Assertion macros shared by the trilinear volume colour modulate RTL.
`ifndef TRILINEAR_VOLUME_COLOUR_MODULATE_MACROS_SVH
`define TRILINEAR_VOLUME_COLOUR_MODULATE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TVCM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define TVCM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tvcm_pkg.sv */
// Types, constants and register codes for the trilinear volume colour modulate block.
package tvcm_pkg;

    localparam int DIM_BITS_DEF  = 5;
    localparam int SAMPLE_BITS   = 16;
    localparam int WEIGHT_BITS   = 25;                 // wx*wy*wz, up to 2^24
    localparam int SUM_BITS      = SAMPLE_BITS + 24;   // trilinear sum, Q.24
    localparam int CFG_ADDR_BITS = 6;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [23:0] GAIN_RESET = 24'd65536;
    localparam logic [23:0] BASE_RESET = 24'hC0C0C0;

    typedef enum logic [2:0] {
        REG_ORIGIN = 3'd0,
        REG_SCALE  = 3'd1,
        REG_DIMS   = 3'd2,
        REG_OFFSET = 3'd3,
        REG_GAIN   = 3'd4,
        REG_BASE   = 3'd5
    } reg_idx_t;

    typedef enum logic {
        REQ_WRITE    = 1'b0,
        REQ_PARTICLE = 1'b1
    } req_type_t;

    typedef struct packed {
        logic               req_type;
        logic [14:0]        voxel_addr;
        logic [15:0]        voxel_value;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         colour_r;
        logic [7:0]         colour_g;
        logic [7:0]         colour_b;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Item fields that ride along the address stages.
    typedef struct packed {
        logic        req_type;
        logic [14:0] voxel_addr;
        logic [15:0] voxel_value;
        rgb_t        rgb;
    } side_t;

    // Settings the shading back end needs.
    typedef struct packed {
        logic [15:0] offset;
        logic [23:0] gain;
        rgb_t        base;
    } shade_cfg_t;

endpackage

/* src/trilinear_volume_colour_modulate.sv */
// Top level: trilinear volume colour modulate with APB settings and voxel store.
//
//  channel  | ports               | handshake          | payload
//  ---------+---------------------+--------------------+----------------------------
//  input    | s_valid/s_ready     | valid & ready      | s_data  (in_item_t)
//  result   | m_valid/m_ready     | valid & ready      | m_data  (out_item_t)
//  settings | psel/penable/pwrite | APB, pready tied 1 | paddr/pwdata/prdata, 64 bit
//
//  One item per cycle sustained while m_ready holds. A particle item passes
//  stages A to P and the output register to m_data; a write item lands in
//  the voxel store as it leaves stage F and gives no result. Every stage
//  moves on one shared enable, so a stall at m_ready freezes the whole pipe
//  and s_ready drops in the same cycle. Reset clears settings and valid bits;
//  the voxel store is not cleared and a voxel reads undefined until written.
//
//  Pipe: A input reg | B pos-origin | C times scale | D floor, frac, clamp |
//  E row offset, wx*wy | F address, full weight | G RAM read (8 copies) |
//  H sample*weight | I pair sums | J total | K..P shade | output register.
`include "trilinear_volume_colour_modulate_macros.svh"

module trilinear_volume_colour_modulate #(
    parameter int DIM_BITS = tvcm_pkg::DIM_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  tvcm_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output tvcm_pkg::out_item_t                m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tvcm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tvcm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tvcm_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import tvcm_pkg::*;

    localparam int ADDR_BITS = 3 * DIM_BITS;
    localparam int DEPTH     = 1 << ADDR_BITS;

    // ---------------------------------------------------------------- settings
    logic [47:0]           origin_reg;
    logic [47:0]           scale_reg;
    logic [ADDR_BITS-1:0]  dims_reg;
    logic [15:0]           offset_reg;
    logic [23:0]           gain_reg;
    logic [23:0]           base_reg;
    logic                  cfg_wr;
    reg_idx_t              cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_reg <= '0;
            scale_reg  <= '0;
            dims_reg   <= '1;
            offset_reg <= '0;
            gain_reg   <= GAIN_RESET;
            base_reg   <= BASE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ORIGIN: origin_reg <= pwdata[47:0];
                REG_SCALE:  scale_reg  <= pwdata[47:0];
                REG_DIMS:   dims_reg   <= pwdata[ADDR_BITS-1:0];
                REG_OFFSET: offset_reg <= pwdata[15:0];
                REG_GAIN:   gain_reg   <= pwdata[23:0];
                REG_BASE:   base_reg   <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ORIGIN: prdata = CFG_DATA_BITS'(origin_reg);
            REG_SCALE:  prdata = CFG_DATA_BITS'(scale_reg);
            REG_DIMS:   prdata = CFG_DATA_BITS'(dims_reg);
            REG_OFFSET: prdata = CFG_DATA_BITS'(offset_reg);
            REG_GAIN:   prdata = CFG_DATA_BITS'(gain_reg);
            REG_BASE:   prdata = CFG_DATA_BITS'(base_reg);
            default:    prdata = '0;
        endcase
    end

    // per-axis size minus one, and size in address width
    logic [DIM_BITS-1:0]  dmax [3];
    logic [ADDR_BITS-1:0] xsz_a, ysz_a;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dmax[k] = dims_reg[k*DIM_BITS +: DIM_BITS];
        end
        xsz_a = ADDR_BITS'(dmax[0]) + ADDR_BITS'(1);
        ysz_a = ADDR_BITS'(dmax[1]) + ADDR_BITS'(1);
    end

    // ---------------------------------------------------------------- flow
    logic pipe_en;
    logic out_vld;

    assign pipe_en = !out_vld || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = out_vld;

    function automatic logic [DIM_BITS-1:0] clamp_idx(input logic signed [26:0] c,
                                                      input logic [DIM_BITS-1:0] mx);
        logic [DIM_BITS-1:0] r;
        if (c < 0) begin
            r = '0;
        end else if (c > $signed(27'(mx))) begin
            r = mx;
        end else begin
            r = c[DIM_BITS-1:0];
        end
        return r;
    endfunction

    // stage A: input register
    logic     a_vld_reg;
    in_item_t a_data_reg;

    // stage B: position minus origin
    logic               b_vld_reg;
    side_t              b_side_reg, b_side_next;
    logic signed [16:0] b_d_reg [3];
    logic signed [16:0] b_d_next [3];
    logic signed [15:0] a_pos [3];

    assign a_pos[0] = a_data_reg.pos_x;
    assign a_pos[1] = a_data_reg.pos_y;
    assign a_pos[2] = a_data_reg.pos_z;

    always_comb begin
        b_side_next.req_type    = a_data_reg.req_type;
        b_side_next.voxel_addr  = a_data_reg.voxel_addr;
        b_side_next.voxel_value = a_data_reg.voxel_value;
        b_side_next.rgb.r       = a_data_reg.colour_r;
        b_side_next.rgb.g       = a_data_reg.colour_g;
        b_side_next.rgb.b       = a_data_reg.colour_b;
        for (int k = 0; k < 3; k++) begin
            b_d_next[k] = 17'(a_pos[k]) - 17'($signed(origin_reg[16*k +: 16]));
        end
    end

    // stage C: grid coordinate in Q.8, less half a voxel
    logic               c_vld_reg;
    side_t              c_side_reg;
    logic signed [33:0] c_g_reg [3];
    logic signed [33:0] c_g_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_g_next[k] = 34'(b_d_reg[k]) * $signed({18'd0, scale_reg[16*k +: 16]})
                        - 34'sd128;
        end
    end

    // stage D: floor cell, fraction, clamped neighbour indices, axis weights
    logic                d_vld_reg;
    side_t               d_side_reg;
    logic [DIM_BITS-1:0] d_idx_reg [3][2];
    logic [DIM_BITS-1:0] d_idx_next [3][2];
    logic [8:0]          d_wt_reg [3][2];
    logic [8:0]          d_wt_next [3][2];
    logic signed [26:0]  cell0 [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            // arithmetic shift keeps the floor for negative coordinates
            cell0[k]         = 27'($signed(c_g_reg[k][33:8]));
            d_idx_next[k][0] = clamp_idx(cell0[k], dmax[k]);
            d_idx_next[k][1] = clamp_idx(cell0[k] + 27'sd1, dmax[k]);
            d_wt_next[k][0]  = 9'd256 - 9'(c_g_reg[k][7:0]);
            d_wt_next[k][1]  = 9'(c_g_reg[k][7:0]);
        end
    end

    // stage E: y/z row offsets and xy weights
    logic                 e_vld_reg;
    side_t                e_side_reg;
    logic [DIM_BITS-1:0]  e_ix_reg [2];
    logic [8:0]           e_wz_reg [2];
    logic [ADDR_BITS-1:0] e_t_reg [2][2];
    logic [ADDR_BITS-1:0] e_t_next [2][2];
    logic [16:0]          e_wxy_reg [2][2];
    logic [16:0]          e_wxy_next [2][2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                // e_t: [oy][oz], e_wxy: [ox][oy]
                e_t_next[i][j]   = ADDR_BITS'(d_idx_reg[1][i])
                                 + ysz_a * ADDR_BITS'(d_idx_reg[2][j]);
                e_wxy_next[i][j] = 17'(d_wt_reg[0][i]) * 17'(d_wt_reg[1][j]);
            end
        end
    end

    // stage F: eight addresses and full weights, corner k = ox + 2*oy + 4*oz
    logic                   f_vld_reg;
    side_t                  f_side_reg;
    logic [ADDR_BITS-1:0]   f_addr_reg [8];
    logic [ADDR_BITS-1:0]   f_addr_next [8];
    logic [WEIGHT_BITS-1:0] f_w_reg [8];
    logic [WEIGHT_BITS-1:0] f_w_next [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            f_addr_next[k] = ADDR_BITS'(e_ix_reg[k % 2]) + xsz_a * e_t_reg[(k / 2) % 2][k / 4];
            f_w_next[k]    = WEIGHT_BITS'(e_wxy_reg[k % 2][(k / 2) % 2])
                           * WEIGHT_BITS'(e_wz_reg[k / 4]);
        end
    end

    // voxel store: one copy per corner, all written together
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] g_smp [8];

    assign ram_we    = pipe_en && f_vld_reg && (f_side_reg.req_type == REQ_WRITE);
    assign ram_waddr = ADDR_BITS'(f_side_reg.voxel_addr);
    assign ram_wdata = SAMPLE_BITS'(f_side_reg.voxel_value);

    for (genvar gk = 0; gk < 8; gk++) begin : g_bank
        tvcm_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk   (aclk),
            .we    (ram_we),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (pipe_en),
            .raddr (f_addr_reg[gk]),
            .rdata (g_smp[gk])
        );
    end

    // stage G: samples out of the store, particles only from here on
    logic                   g_vld_reg;
    rgb_t                   g_rgb_reg;
    logic [WEIGHT_BITS-1:0] g_w_reg [8];

    // stage H: weighted samples
    logic                h_vld_reg;
    rgb_t                h_rgb_reg;
    logic [SUM_BITS-1:0] h_p_reg [8];
    logic [SUM_BITS-1:0] h_p_next [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            h_p_next[k] = SUM_BITS'(g_smp[k]) * SUM_BITS'(g_w_reg[k]);
        end
    end

    // stage I: pair sums; stage J: total (weights sum to 2^24, no overflow)
    logic                i_vld_reg;
    rgb_t                i_rgb_reg;
    logic [SUM_BITS-1:0] i_s_reg [4];
    logic [SUM_BITS-1:0] i_s_next [4];
    logic                j_vld_reg;
    rgb_t                j_rgb_reg;
    logic [SUM_BITS-1:0] j_sum_reg, j_sum_next;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            i_s_next[k] = h_p_reg[2*k] + h_p_reg[2*k+1];
        end
        j_sum_next = (i_s_reg[0] + i_s_reg[1]) + (i_s_reg[2] + i_s_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            a_vld_reg <= s_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg && (f_side_reg.req_type == REQ_PARTICLE);
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_data_reg <= s_data;
            b_side_reg <= b_side_next;
            b_d_reg    <= b_d_next;
            c_side_reg <= b_side_reg;
            c_g_reg    <= c_g_next;
            d_side_reg <= c_side_reg;
            d_idx_reg  <= d_idx_next;
            d_wt_reg   <= d_wt_next;
            e_side_reg <= d_side_reg;
            e_ix_reg   <= d_idx_reg[0];
            e_wz_reg   <= d_wt_reg[2];
            e_t_reg    <= e_t_next;
            e_wxy_reg  <= e_wxy_next;
            f_side_reg <= e_side_reg;
            f_addr_reg <= f_addr_next;
            f_w_reg    <= f_w_next;
            g_rgb_reg  <= f_side_reg.rgb;
            g_w_reg    <= f_w_reg;
            h_rgb_reg  <= g_rgb_reg;
            h_p_reg    <= h_p_next;
            i_rgb_reg  <= h_rgb_reg;
            i_s_reg    <= i_s_next;
            j_rgb_reg  <= i_rgb_reg;
            j_sum_reg  <= j_sum_next;
        end
    end

    // ---------------------------------------------------------------- shading
    shade_cfg_t shade_cfg;

    assign shade_cfg.offset = offset_reg;
    assign shade_cfg.gain   = gain_reg;
    assign shade_cfg.base   = rgb_t'(base_reg);

    tvcm_shade u_shade (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .cfg      (shade_cfg),
        .in_vld   (j_vld_reg),
        .in_sum   (j_sum_reg),
        .in_rgb   (j_rgb_reg),
        .out_vld  (out_vld),
        .out_data (m_data)
    );

    // ---------------------------------------------------------------- checks
    logic [9:0]  vld_vec;
    logic [27:0] f_wsum;

    assign vld_vec = {a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg, e_vld_reg,
                      f_vld_reg, g_vld_reg, h_vld_reg, i_vld_reg, j_vld_reg};

    always_comb begin
        f_wsum = '0;
        for (int k = 0; k < 8; k++) begin
            f_wsum = f_wsum + 28'(f_w_reg[k]);
        end
    end

    `TVCM_ASSERT_NOW(a_no_write_in_stall, !pipe_en, !ram_we, "voxel store written during a stall")
    `TVCM_ASSERT_NEXT(a_stall_holds_pipe, !pipe_en, $stable(vld_vec), "pipe moved during a stall")
    `TVCM_ASSERT_NOW(a_weights_unity, f_vld_reg && (f_side_reg.req_type == REQ_PARTICLE), f_wsum == 28'd16777216, "corner weights do not sum to one")

endmodule

/* src/tvcm_ram.sv */
// Generic simple dual-port RAM with registered read.
module tvcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/tvcm_shade.sv */
// Shading back end: normalize, weight clamp, smoothstep, colour blend, output register.
module tvcm_shade (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tvcm_pkg::shade_cfg_t          cfg,
    input  logic                          in_vld,
    input  logic [tvcm_pkg::SUM_BITS-1:0] in_sum,
    input  tvcm_pkg::rgb_t                in_rgb,
    output logic                          out_vld,
    output tvcm_pkg::out_item_t           out_data
);
    import tvcm_pkg::*;

    // x / 65535 saturates at one from here on
    localparam logic [40:0] SAT_LIM = 41'd4294967295;

    logic        k_vld_reg, l_vld_reg, m_vld_reg, n_vld_reg, o_vld_reg, p_vld_reg;
    logic        q_vld_reg;
    rgb_t        k_rgb_reg, l_rgb_reg, m_rgb_reg, n_rgb_reg, o_rgb_reg, p_rgb_reg;
    logic [24:0] k_d_reg, k_d_next;
    logic [40:0] l_x_reg, l_x_next;
    logic [16:0] m_w_reg, m_w_next;
    logic [33:0] n_w2_reg, n_w2_next;
    logic [18:0] n_k_reg, n_k_next;
    logic [49:0] o_t_reg, o_t_next;
    logic [16:0] p_s_reg, p_s_next;
    out_item_t   q_data_reg, q_data_next;

    logic [24:0] interp8;
    logic [24:0] off8;
    logic [48:0] prod_dg;
    logic [41:0] div_sum;
    logic [50:0] t_round;

    function automatic logic [7:0] blend8(input logic [16:0] s, input logic [7:0] c,
                                          input logic [7:0] b);
        logic [25:0] acc;
        logic [9:0]  v;
        acc = 26'(s) * 26'(c) + 26'(17'd65536 - s) * 26'(b);
        v   = acc[25:16];
        return (v > 10'd255) ? 8'hFF : v[7:0];
    endfunction

    always_comb begin
        interp8  = 25'((41'(in_sum) + 41'd32768) >> 16);
        off8     = {1'b0, cfg.offset, 8'h00};
        k_d_next = (interp8 > off8) ? (interp8 - off8) : '0;

        prod_dg  = 49'(k_d_reg) * 49'(cfg.gain);
        l_x_next = prod_dg[48:8];

        div_sum  = 42'(l_x_reg) + 42'(l_x_reg >> 16) + 42'd1;
        m_w_next = (l_x_reg >= SAT_LIM) ? 17'd65536 : div_sum[32:16];

        n_w2_next = 34'(m_w_reg) * 34'(m_w_reg);
        n_k_next  = 19'd196608 - {1'b0, m_w_reg, 1'b0};

        o_t_next = 50'(n_w2_reg) * 50'(n_k_reg);

        t_round  = 51'(o_t_reg) + 51'h0_0000_8000_0000;
        p_s_next = t_round[48:32];

        q_data_next.out_r = blend8(p_s_reg, p_rgb_reg.r, cfg.base.r);
        q_data_next.out_g = blend8(p_s_reg, p_rgb_reg.g, cfg.base.g);
        q_data_next.out_b = blend8(p_s_reg, p_rgb_reg.b, cfg.base.b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_vld_reg <= 1'b0;
            l_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            n_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
        end else if (en) begin
            k_vld_reg <= in_vld;
            l_vld_reg <= k_vld_reg;
            m_vld_reg <= l_vld_reg;
            n_vld_reg <= m_vld_reg;
            o_vld_reg <= n_vld_reg;
            p_vld_reg <= o_vld_reg;
            q_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_d_reg    <= k_d_next;
            k_rgb_reg  <= in_rgb;
            l_x_reg    <= l_x_next;
            l_rgb_reg  <= k_rgb_reg;
            m_w_reg    <= m_w_next;
            m_rgb_reg  <= l_rgb_reg;
            n_w2_reg   <= n_w2_next;
            n_k_reg    <= n_k_next;
            n_rgb_reg  <= m_rgb_reg;
            o_t_reg    <= o_t_next;
            o_rgb_reg  <= n_rgb_reg;
            p_s_reg    <= p_s_next;
            p_rgb_reg  <= o_rgb_reg;
            q_data_reg <= q_data_next;
        end
    end

    assign out_vld  = q_vld_reg;
    assign out_data = q_data_reg;

endmodule

/* sim/trilinear_volume_colour_modulate_test.sv */
// Self-checking testbench for the trilinear volume colour modulate block.
`timescale 1ns / 1ps

module trilinear_volume_colour_modulate_test;
    import tvcm_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYCLES = 24;   // margin for the last voxel write to land

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_item_t                m_data;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr = '0;
    logic [CFG_DATA_BITS-1:0] pwdata = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Mirror of the block's settings and voxel store
    logic [47:0] grid_origin_q;
    logic [47:0] grid_scale_q;
    logic [14:0] grid_dims_q;
    logic [15:0] value_offset_q;
    logic [23:0] value_gain_q;
    logic [23:0] base_colour_q;
    logic [15:0] voxel_mirror [32768];
    bit          voxel_written [32768];

    out_item_t expected_colours [$];
    int        colour_errors = 0;
    int        particles_sent = 0;
    int        voxels_sent = 0;
    int        colours_checked = 0;
    bit        calm = 1'b0;    // no idling on either side
    int        stall_left = 0;

    trilinear_volume_colour_modulate u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Receiver stalls in random bursts, except while calm
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: every accepted colour against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colours.size() == 0) begin
                $display("%0t: unexpected colour, expected none, actual %h", $realtime, m_data);
                colour_errors++;
            end else begin
                want = expected_colours.pop_front();
                colours_checked++;
                if (m_data.out_r !== want.out_r) begin
                    $display("%0t: out_r expected %h actual %h", $realtime, want.out_r,
                             m_data.out_r);
                    colour_errors++;
                end
                if (m_data.out_g !== want.out_g) begin
                    $display("%0t: out_g expected %h actual %h", $realtime, want.out_g,
                             m_data.out_g);
                    colour_errors++;
                end
                if (m_data.out_b !== want.out_b) begin
                    $display("%0t: out_b expected %h actual %h", $realtime, want.out_b,
                             m_data.out_b);
                    colour_errors++;
                end
            end
        end
    end

    function automatic longint clamp_axis(longint i, longint top);
        if (i < 0) return 0;
        if (i > top) return top;
        return i;
    endfunction

    function automatic longint blend_channel(longint s, longint c, longint b);
        longint v;
        v = (s * c + (65536 - s) * b) >>> 16;
        return (v > 255) ? 255 : v;
    endfunction

    // Expected colour of one particle from the mirrored settings and store
    function automatic out_item_t shade_particle(in_item_t it);
        longint    pos [3];
        longint    top [3];
        longint    frac [3];
        longint    near [3][2];
        longint    g, cell_lo, sum, wgt, addr, interp, off8, w, t, s;
        out_item_t res;
        pos[0] = longint'($signed(it.pos_x));
        pos[1] = longint'($signed(it.pos_y));
        pos[2] = longint'($signed(it.pos_z));
        for (int a = 0; a < 3; a++) begin
            top[a] = longint'(grid_dims_q[5*a +: 5]);
            g = (pos[a] - longint'($signed(grid_origin_q[16*a +: 16])))
                * longint'(grid_scale_q[16*a +: 16]) - 128;
            frac[a] = g & 255;
            cell_lo = g >>> 8;     // floor, not truncation
            near[a][0] = clamp_axis(cell_lo, top[a]);
            near[a][1] = clamp_axis(cell_lo + 1, top[a]);
        end
        sum = 0;
        for (int oz = 0; oz < 2; oz++)
            for (int oy = 0; oy < 2; oy++)
                for (int ox = 0; ox < 2; ox++) begin
                    wgt = (ox ? frac[0] : 256 - frac[0]) * (oy ? frac[1] : 256 - frac[1])
                          * (oz ? frac[2] : 256 - frac[2]);
                    addr = near[0][ox] + (top[0] + 1) * (near[1][oy] + (top[1] + 1) * near[2][oz]);
                    sum += longint'(voxel_mirror[15'(addr)]) * wgt;
                end
        interp = (sum + 32768) >>> 16;
        off8 = longint'(value_offset_q) << 8;
        if (interp <= off8) begin
            w = 0;          // below the offset: base colour
        end else begin
            w = (((interp - off8) * longint'(value_gain_q)) >>> 8) / 65535;
            if (w > 65536) w = 65536;
        end
        t = w * w * (3 * 65536 - 2 * w);
        s = (t + (longint'(1) << 31)) >>> 32;
        res.out_r = 8'(blend_channel(s, it.colour_r, base_colour_q[23:16]));
        res.out_g = 8'(blend_channel(s, it.colour_g, base_colour_q[15:8]));
        res.out_b = 8'(blend_channel(s, it.colour_b, base_colour_q[7:0]));
        return res;
    endfunction

    // Hand one item to the block; predicts at acceptance
    task automatic send_item(in_item_t it);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.req_type == REQ_PARTICLE) begin
            expected_colours.push_back(shade_particle(it));
            particles_sent++;
        end else begin
            voxel_mirror[it.voxel_addr] = it.voxel_value;
            voxel_written[it.voxel_addr] = 1'b1;
            voxels_sent++;
        end
    endtask

    task automatic write_voxel(logic [14:0] addr, logic [15:0] value);
        in_item_t it;
        // junk in the ignored fields
        it = in_item_t'(104'({$urandom, $urandom, $urandom, $urandom}));
        it.req_type = REQ_WRITE;
        it.voxel_addr = addr;
        it.voxel_value = value;
        send_item(it);
    endtask

    task automatic shade(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [23:0] rgb);
        in_item_t it;
        it = in_item_t'(104'({$urandom, $urandom, $urandom, $urandom}));
        it.req_type = REQ_PARTICLE;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        {it.colour_r, it.colour_g, it.colour_b} = rgb;
        send_item(it);
    endtask

    // Stop sending and wait out every outstanding item
    task automatic drain(int extra);
        s_valid <= 1'b0;
        while (expected_colours.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic set_reg(reg_idx_t idx, logic [63:0] value);
        drain(DRAIN_CYCLES);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ORIGIN: grid_origin_q = value[47:0];
            REG_SCALE:  grid_scale_q = value[47:0];
            REG_DIMS:   grid_dims_q = value[14:0];
            REG_OFFSET: value_offset_q = value[15:0];
            REG_GAIN:   value_gain_q = value[23:0];
            REG_BASE:   base_colour_q = value[23:0];
            default: ;
        endcase
    endtask

    // Make sure every voxel the current grid can fetch holds a value
    task automatic fill_grid();
        int cells;
        cells = (int'(grid_dims_q[4:0]) + 1) * (int'(grid_dims_q[9:5]) + 1)
                * (int'(grid_dims_q[14:10]) + 1);
        for (int i = 0; i < cells; i++)
            if (!voxel_written[i]) write_voxel(i[14:0], 16'($urandom));
    endtask

    // Position that lands from a few voxels below to a few above the grid on one axis
    function automatic logic [15:0] near_pos(int a);
        int org, sc, top, reach;
        org = int'($signed(grid_origin_q[16*a +: 16]));
        sc = int'(grid_scale_q[16*a +: 16]);
        top = int'(grid_dims_q[5*a +: 5]);
        reach = (sc == 0) ? 64 : ((top + 5) * 256) / sc + 1;
        if (reach > 30000) reach = 30000;
        return 16'(org - reach / 8 + $urandom_range(0, reach));
    endfunction

    task automatic random_particle();
        if ($urandom_range(0, 7) == 0)
            shade(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
        else
            shade(near_pos(0), near_pos(1), near_pos(2), 24'($urandom));
    endtask

    // Default settings: zero scale pins every particle to voxel 0
    task automatic test_reset_settings();
        write_voxel(15'd0, 16'hFFFF);
        shade(16'h7FFF, 16'h8000, 16'h0000, 24'h00FF80);
        write_voxel(15'd0, 16'h0000);
        shade(16'h8000, 16'h7FFF, 16'h1234, 24'hFF00FF);
        write_voxel(15'd0, 16'h8000);
        shade(16'($urandom), 16'($urandom), 16'($urandom), 24'hFFFFFF);
    endtask

    // Weight below zero, saturating weight, colour extremes, single-voxel grid
    task automatic test_weight_edges();
        set_reg(REG_DIMS, 64'h0421);            // 2 x 2 x 2
        set_reg(REG_ORIGIN, 64'h0000_0000_0000);
        set_reg(REG_SCALE, 64'h0100_0100_0100);
        set_reg(REG_BASE, 64'h000000);
        write_voxel(15'd7, 16'hFFFF);
        write_voxel(15'h7FFF, 16'h1111);        // outside the grid, never fetched
        fill_grid();
        shade(16'd1, 16'd1, 16'd1, 24'hFFFFFF);
        shade(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h80FF01);
        set_reg(REG_OFFSET, 64'hFFFF);          // everything below the offset
        shade(16'd0, 16'd1, 16'd0, 24'hFFFFFF);
        set_reg(REG_OFFSET, 64'h0000);
        set_reg(REG_GAIN, 64'hFFFFFF);          // saturates at one
        set_reg(REG_BASE, 64'hFFFFFF);
        shade(16'd0, 16'd0, 16'd1, 24'h000000);
        set_reg(REG_GAIN, 64'h000000);
        shade(16'd1, 16'd0, 16'd0, 24'h123456);
        set_reg(REG_DIMS, 64'h0000);            // one voxel
        set_reg(REG_GAIN, 64'd65536);
        shade(16'h7FFF, 16'h8000, 16'd0, 24'hA5A5A5);
    endtask

    // Widest x axis (32 x 2 x 1), every voxel given a value, extreme scale and origin
    task automatic test_full_grid();
        set_reg(REG_DIMS, 64'h003F);
        set_reg(REG_SCALE, 64'hFFFF_0080_0100);
        set_reg(REG_ORIGIN, 64'h8000_7FFF_0000);
        set_reg(REG_BASE, 64'h406080);
        fill_grid();
        repeat (20) random_particle();
        set_reg(REG_SCALE, 64'h0020_0040_0100);
        set_reg(REG_ORIGIN, 64'hFFF0_0010_FFFF);
        repeat (20) random_particle();
    endtask

    // Random settings per phase, then a mix of particles and voxel writes
    task automatic test_random_phases();
        logic [47:0] sc;
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 9) calm = 1'b1;
            set_reg(REG_DIMS, 64'({5'($urandom_range(0, 3)), 5'($urandom_range(0, 3)),
                                   5'($urandom_range(0, 3))}));
            set_reg(REG_ORIGIN, ($urandom_range(0, 3) == 0) ? 64'({$urandom, $urandom})
                    : 64'({16'($urandom_range(0, 600) - 300), 16'($urandom_range(0, 600) - 300),
                           16'($urandom_range(0, 600) - 300)}));
            sc = {16'($urandom_range(16, 1024)), 16'($urandom_range(16, 1024)),
                  16'($urandom_range(16, 1024))};
            if (phase == 4) sc = '0;
            if (phase == 5) sc = 48'hFFFF_FFFF_FFFF;
            if (phase == 6) sc = 48'({$urandom, $urandom});
            set_reg(REG_SCALE, 64'(sc));
            set_reg(REG_OFFSET, ($urandom_range(0, 3) == 0) ? 64'($urandom)
                    : 64'($urandom_range(0, 8192)));
            set_reg(REG_GAIN, ($urandom_range(0, 3) == 0) ? 64'($urandom)
                    : 64'($urandom_range(65536, 262144)));
            set_reg(REG_BASE, 64'($urandom));
            fill_grid();
            for (int n = 0; n < 54; n++) begin
                if (phase == 3 && n == 30) drain(0);    // sender waits for every colour
                case ($urandom_range(0, 19))
                    0, 1: write_voxel(15'($urandom), 16'($urandom));
                    2: write_voxel(15'($urandom_range(0, 63)), 16'($urandom));
                    default: random_particle();
                endcase
            end
            fill_grid();    // stray writes may have grown the set, harmless
        end
    endtask

    initial begin
        grid_origin_q = '0;
        grid_scale_q = '0;
        grid_dims_q = '1;
        value_offset_q = '0;
        value_gain_q = GAIN_RESET;
        base_colour_q = BASE_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_weight_edges();
        test_full_grid();
        test_random_phases();
        drain(DRAIN_CYCLES);
        $display("%0d particles and %0d voxel writes sent, %0d colours checked",
                 particles_sent, voxels_sent, colours_checked);
        $display("settings swept: grid sizes 1 to 32768, zero and full scale, weight clamps");
        if (colour_errors == 0 && expected_colours.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(12 * 600000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
